FILE: src/nacs_pkg.sv
`default_nettype none

package nacs_pkg;

    // Field widths fixed by the frame format.
    localparam int ID_W      = 48;
    localparam int ALIAS_W   = 12;
    localparam int CNT_W     = 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd2;

    // Configuration reset values.
    localparam logic [CNT_W-1:0] WAIT_LIMIT_RST  = 8'd2;
    localparam logic [CNT_W-1:0] RETRY_LIMIT_RST = 8'd10;
    localparam logic [CNT_W-1:0] CNT_MAX         = 8'hFF;

    // Frame kinds.
    localparam logic [2:0] FK_STATUS  = 3'd0;
    localparam logic [2:0] FK_CHECK   = 3'd1;
    localparam logic [2:0] FK_RESERVE = 3'd2;
    localparam logic [2:0] FK_MAP     = 3'd3;
    localparam logic [2:0] FK_INIT    = 3'd4;

    // Claim phase codes as seen on the result channel.
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_CHECK     = 3'd1;
    localparam logic [2:0] PH_WAIT      = 3'd2;
    localparam logic [2:0] PH_CONFLICT  = 3'd3;
    localparam logic [2:0] PH_CONFIRMED = 3'd4;

    // Check frame sequence number of the first check frame.
    localparam logic [2:0] CHECK_SEQ_FIRST = 3'd7;

    // Input event.
    typedef struct packed {
        logic func;
        logic slot_free;
    } t_in_item;

    // One result frame.
    typedef struct packed {
        logic [2:0]         frame_kind;
        logic [2:0]         check_seq;
        logic [ALIAS_W-1:0] check_field;
        logic [ALIAS_W-1:0] alias_out;
        logic [ID_W-1:0]    id_payload;
        logic               take_slot;
        logic               release_slot;
        logic [2:0]         phase_out;
        logic               last;
    } t_out_item;

    // Which frame burst an accepted event produces.
    typedef enum logic [1:0] {
        BURST_STATUS,
        BURST_CHECK,
        BURST_CONFIRM,
        BURST_RESERVE
    } t_burst;

    // Work descriptor handed from the front end to the frame sequencer.
    typedef struct packed {
        t_burst             burst;
        logic [ALIAS_W-1:0] alias_val;
        logic [2:0]         phase;
        logic               rel;
    } t_job;

    // Initial alias: XOR fold of the four 12-bit slices of the node ID.
    function automatic logic [ALIAS_W-1:0] seed_alias(input logic [ID_W-1:0] id);
        logic [ALIAS_W-1:0] s;
        s = id[47:36] ^ id[35:24] ^ id[23:12] ^ id[11:0];
        return (s == '0) ? ALIAS_W'(1) : s;
    endfunction

    // Next alias from a 12-bit LFSR; zero is skipped.
    function automatic logic [ALIAS_W-1:0] next_alias(input logic [ALIAS_W-1:0] a);
        logic               fb;
        logic [ALIAS_W-1:0] n;
        fb = a[0] ^ a[2] ^ a[3] ^ a[11];
        n  = {fb, a[11:1]};
        return (n == '0) ? ALIAS_W'(1) : n;
    endfunction

endpackage

`default_nettype wire

FILE: src/node_alias_claim_sequencer.sv
`default_nettype none

// Node alias claim sequencer. Each input transfer is a tick or a collision
// report; the front end updates the claim state at once and queues a burst
// descriptor, and the frame sequencer behind the queue sends the burst's
// frames, one result transfer per cycle while the output accepts them,
// through a registered output stage. An event producing n frames (1 to 4)
// occupies the sequencer until its last frame is loaded. The front end
// keeps taking events while the job queue has room, so up to Q_DEPTH
// events may wait behind a stalled output. Configuration writes take
// effect at once and must only be made while the block is idle.
module node_alias_claim_sequencer #(
    parameter int Q_DEPTH = 2
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [nacs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [nacs_pkg::ID_W-1:0]         i_cfg_wdata,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire nacs_pkg::t_in_item                i_in,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output nacs_pkg::t_out_item                    o_out
);

    logic [nacs_pkg::ID_W-1:0]  r_node_id;
    logic [nacs_pkg::CNT_W-1:0] r_wait_limit;
    logic [nacs_pkg::CNT_W-1:0] r_retry_limit;
    logic                       q_full;
    logic                       push;
    nacs_pkg::t_job             push_job;
    logic                       pop;
    logic                       job_valid;
    nacs_pkg::t_job             job;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id     <= '0;
            r_wait_limit  <= nacs_pkg::WAIT_LIMIT_RST;
            r_retry_limit <= nacs_pkg::RETRY_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                nacs_pkg::CFG_NODE_ID:     r_node_id     <= i_cfg_wdata;
                nacs_pkg::CFG_WAIT_LIMIT:  r_wait_limit  <= i_cfg_wdata[nacs_pkg::CNT_W-1:0];
                nacs_pkg::CFG_RETRY_LIMIT: r_retry_limit <= i_cfg_wdata[nacs_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Event classification and claim state.
    nacs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in          (i_in),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (push_job),
        .i_node_id     (r_node_id),
        .i_wait_limit  (r_wait_limit),
        .i_retry_limit (r_retry_limit)
    );

    // Job queue between the two halves.
    nacs_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_data  (job)
    );

    // Frame sequencer and output stage.
    nacs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (pop),
        .i_node_id   (r_node_id),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: src/nacs_front.sv
`default_nettype none

module nacs_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire nacs_pkg::t_in_item            i_in,
    input  wire logic                          i_q_full,
    output logic                               o_push,
    output nacs_pkg::t_job                     o_job,
    input  wire logic [nacs_pkg::ID_W-1:0]     i_node_id,
    input  wire logic [nacs_pkg::CNT_W-1:0]    i_wait_limit,
    input  wire logic [nacs_pkg::CNT_W-1:0]    i_retry_limit
);

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_CHECK     = 3'd1,
        ST_WAIT      = 3'd2,
        ST_CONFLICT  = 3'd3,
        ST_CONFIRMED = 3'd4
    } t_phase;

    t_phase                           r_phase, n_phase;
    logic [nacs_pkg::ALIAS_W-1:0]     r_alias, n_alias;
    logic [nacs_pkg::CNT_W-1:0]       r_wait, n_wait;
    logic [nacs_pkg::CNT_W-1:0]       r_retry, n_retry;
    nacs_pkg::t_burst                 burst;
    logic                             rel;
    logic                             accept;

    // An event is taken whenever the job queue has room.
    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept;

    // Claim protocol: next state and the burst this event produces.
    always_comb begin
        n_phase = r_phase;
        n_alias = r_alias;
        n_wait  = r_wait;
        n_retry = r_retry;
        burst   = nacs_pkg::BURST_STATUS;
        rel     = 1'b0;
        if (!i_in.func) begin
            unique case (r_phase)
                ST_IDLE: begin
                    if (r_alias == '0) begin
                        n_alias = nacs_pkg::seed_alias(i_node_id);
                    end
                    if (i_in.slot_free) begin
                        burst   = nacs_pkg::BURST_CHECK;
                        n_phase = ST_CHECK;
                        n_wait  = '0;
                    end
                end
                ST_CHECK: begin
                    n_phase = ST_WAIT;
                    n_wait  = '0;
                end
                ST_WAIT: begin
                    if (r_wait != nacs_pkg::CNT_MAX) begin
                        n_wait = r_wait + 1'b1;
                    end
                    if (n_wait >= i_wait_limit) begin
                        burst   = nacs_pkg::BURST_CONFIRM;
                        n_phase = ST_CONFIRMED;
                    end
                end
                ST_CONFLICT: begin
                    if (r_retry != nacs_pkg::CNT_MAX) begin
                        n_retry = r_retry + 1'b1;
                    end
                    rel = 1'b1;
                    if (n_retry < i_retry_limit) begin
                        n_alias = nacs_pkg::next_alias(r_alias);
                        n_phase = ST_IDLE;
                    end
                end
                ST_CONFIRMED: begin
                end
            endcase
        end else begin
            priority if (r_phase == ST_CHECK || r_phase == ST_WAIT) begin
                n_phase = ST_CONFLICT;
            end else if (r_phase == ST_CONFIRMED) begin
                burst = nacs_pkg::BURST_RESERVE;
            end else begin
                // A collision while idle or in conflict only reports status.
            end
        end
    end

    // Descriptor for the frame sequencer.
    always_comb begin
        o_job.burst     = burst;
        o_job.alias_val = n_alias;
        o_job.phase     = n_phase;
        o_job.rel       = rel;
    end

    // Claim state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ST_IDLE;
            r_alias <= '0;
            r_wait  <= '0;
            r_retry <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_alias <= n_alias;
            r_wait  <= n_wait;
            r_retry <= n_retry;
        end
    end

endmodule

`default_nettype wire

FILE: src/nacs_queue.sv
`default_nettype none

module nacs_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire nacs_pkg::t_job i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output nacs_pkg::t_job      o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    nacs_pkg::t_job     r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr;
    logic [PTR_W-1:0]   r_rptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/nacs_back.sv
`default_nettype none

module nacs_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_job_valid,
    input  wire nacs_pkg::t_job            i_job,
    output logic                           o_pop,
    input  wire logic [nacs_pkg::ID_W-1:0] i_node_id,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output nacs_pkg::t_out_item            o_out
);

    logic                   r_busy;
    nacs_pkg::t_job         r_job;
    logic [1:0]             r_idx;
    logic                   r_out_valid;
    nacs_pkg::t_out_item    r_out;
    nacs_pkg::t_out_item    res;
    logic                   can_load;
    logic                   emit;
    logic                   finishing;

    assign can_load  = !r_out_valid || i_out_ready;
    assign emit      = can_load && r_busy;
    assign finishing = emit && res.last;
    assign o_pop     = i_job_valid && (!r_busy || finishing);

    // Build the frame at the current position of the burst.
    always_comb begin
        res              = '0;
        res.alias_out    = r_job.alias_val;
        res.phase_out    = r_job.phase;
        unique case (r_job.burst)
            nacs_pkg::BURST_STATUS: begin
                res.frame_kind   = nacs_pkg::FK_STATUS;
                res.release_slot = r_job.rel;
                res.last         = 1'b1;
            end
            nacs_pkg::BURST_CHECK: begin
                res.frame_kind = nacs_pkg::FK_CHECK;
                res.check_seq  = nacs_pkg::CHECK_SEQ_FIRST - {1'b0, r_idx};
                res.take_slot  = (r_idx == 2'd0);
                res.last       = (r_idx == 2'd3);
                unique case (r_idx)
                    2'd0: res.check_field = i_node_id[47:36];
                    2'd1: res.check_field = i_node_id[35:24];
                    2'd2: res.check_field = i_node_id[23:12];
                    2'd3: res.check_field = i_node_id[11:0];
                endcase
            end
            nacs_pkg::BURST_CONFIRM: begin
                priority if (r_idx == 2'd0) begin
                    res.frame_kind = nacs_pkg::FK_RESERVE;
                end else if (r_idx == 2'd1) begin
                    res.frame_kind = nacs_pkg::FK_MAP;
                    res.id_payload = i_node_id;
                end else begin
                    res.frame_kind   = nacs_pkg::FK_INIT;
                    res.id_payload   = i_node_id;
                    res.release_slot = 1'b1;
                    res.last         = 1'b1;
                end
            end
            nacs_pkg::BURST_RESERVE: begin
                res.frame_kind = nacs_pkg::FK_RESERVE;
                res.last       = 1'b1;
            end
        endcase
    end

    // Burst sequencer: one frame per cycle while the output stage can take it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (finishing) begin
            r_busy <= 1'b0;
        end else if (emit) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
